[src/gp_kernel_pair_evaluator_unit_defines.svh]
// Assertion macros used by the kernel pair evaluator sequencer
`ifndef GP_KERNEL_PAIR_EVALUATOR_UNIT_DEFINES_SVH
`define GP_KERNEL_PAIR_EVALUATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define GPKPE_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("gpkpe assertion failed");

// next-cycle implication
`define GPKPE_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("gpkpe assertion failed");

`endif

[src/gpkpe_pkg.sv]
// Types, constants and tables shared by the kernel pair evaluator
package gpkpe_pkg;

	localparam int COORD_WIDTH           = 24;
	localparam int PRODUCT_FRAC_BITS_DEF = 32;
	localparam int STEP_W                = 5;
	localparam logic [STEP_W-1:0] LAST_STEP = 5'd21;

	localparam logic [31:0] SQRT5_Q30 = 32'd2400959709;

	// configuration register indexes
	localparam logic [1:0] CFG_KERNEL_TYPE  = 2'd0;
	localparam logic [1:0] CFG_OUTPUT_SCALE = 2'd1;
	localparam logic [1:0] CFG_NUGGET       = 2'd2;

	localparam logic KT_MATERN = 1'b1;

	// datapath operations
	localparam logic [3:0] OP_NONE  = 4'd0;
	localparam logic [3:0] OP_LOAD  = 4'd1;
	localparam logic [3:0] OP_PREP  = 4'd2;
	localparam logic [3:0] OP_ARG   = 4'd3;
	localparam logic [3:0] OP_DIV   = 4'd4;
	localparam logic [3:0] OP_GW1   = 4'd5;
	localparam logic [3:0] OP_GW2   = 4'd6;
	localparam logic [3:0] OP_POLY1 = 4'd7;
	localparam logic [3:0] OP_POLY2 = 4'd8;
	localparam logic [3:0] OP_EXP   = 4'd9;
	localparam logic [3:0] OP_FAC   = 4'd10;
	localparam logic [3:0] OP_MUL1  = 4'd11;
	localparam logic [3:0] OP_MUL2  = 4'd12;
	localparam logic [3:0] OP_OUT1  = 4'd13;
	localparam logic [3:0] OP_OUT2  = 4'd14;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] first_value;
		logic signed [COORD_WIDTH-1:0] second_value;
		logic [COORD_WIDTH-1:0]        dim_weight;
		logic                          latent_dim;
		logic                          on_diagonal;
		logic                          last_dim;
	} item_t;

	typedef struct packed {
		logic [31:0] kernel_value;
		logic        saturated;
	} result_t;

	typedef struct packed {
		logic [3:0]        op;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic matern;
		logic latent;
		logic last;
		logic div_skip;
		logic out_free;
	} sts_t;

	// exp(-2^(k-16)) in Q0.32
	function automatic logic [31:0] exp_bit(input logic [STEP_W-1:0] k);
		logic [31:0] e;
		case (k)
			5'd0:    e = 32'd4294901760;
			5'd1:    e = 32'd4294836226;
			5'd2:    e = 32'd4294705160;
			5'd3:    e = 32'd4294443040;
			5'd4:    e = 32'd4293918848;
			5'd5:    e = 32'd4292870656;
			5'd6:    e = 32'd4290775039;
			5'd7:    e = 32'd4286586875;
			5'd8:    e = 32'd4278222805;
			5'd9:    e = 32'd4261543595;
			5'd10:   e = 32'd4228380000;
			5'd11:   e = 32'd4162825044;
			5'd12:   e = 32'd4034748382;
			5'd13:   e = 32'd3790295335;
			5'd14:   e = 32'd3344923893;
			5'd15:   e = 32'd2605029347;
			5'd16:   e = 32'd1580030169;
			5'd17:   e = 32'd581260615;
			5'd18:   e = 32'd78665070;
			5'd19:   e = 32'd1440801;
			5'd20:   e = 32'd483;
			default: e = 32'd0;
		endcase
		return e;
	endfunction

endpackage

[src/gpkpe_ctrl.sv]
// Sequencer for the kernel pair evaluator
`include "gp_kernel_pair_evaluator_unit_defines.svh"

module gpkpe_ctrl
	import gpkpe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PREP  = 4'd1;
	localparam logic [3:0] S_ARG   = 4'd2;
	localparam logic [3:0] S_DIV   = 4'd3;
	localparam logic [3:0] S_GW1   = 4'd4;
	localparam logic [3:0] S_GW2   = 4'd5;
	localparam logic [3:0] S_POLY1 = 4'd6;
	localparam logic [3:0] S_POLY2 = 4'd7;
	localparam logic [3:0] S_EXP   = 4'd8;
	localparam logic [3:0] S_FAC   = 4'd9;
	localparam logic [3:0] S_MUL1  = 4'd10;
	localparam logic [3:0] S_MUL2  = 4'd11;
	localparam logic [3:0] S_OUT1  = 4'd12;
	localparam logic [3:0] S_OUT2  = 4'd13;

	logic [3:0]        state_q, state_n;
	logic [STEP_W-1:0] cnt_q, cnt_n;

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		state_n = state_q;
		cmd.op  = OP_NONE;
		cmd.step = cnt_q;
		cnt_n   = '0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.op  = OP_LOAD;
					state_n = S_PREP;
				end
			end
			S_PREP: begin
				cmd.op  = OP_PREP;
				state_n = S_ARG;
			end
			S_ARG: begin
				cmd.op = OP_ARG;
				if (sts.matern) begin
					state_n = (sts.latent || sts.div_skip) ? S_POLY1 : S_DIV;
				end else begin
					state_n = S_GW1;
				end
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				if (cnt_q == LAST_STEP) begin
					state_n = S_POLY1;
				end else begin
					cnt_n = cnt_q + 1'b1;
				end
			end
			S_GW1: begin
				cmd.op  = OP_GW1;
				state_n = sts.latent ? S_EXP : S_GW2;
			end
			S_GW2: begin
				cmd.op  = OP_GW2;
				state_n = S_EXP;
			end
			S_POLY1: begin
				cmd.op  = OP_POLY1;
				state_n = S_POLY2;
			end
			S_POLY2: begin
				cmd.op  = OP_POLY2;
				state_n = S_EXP;
			end
			S_EXP: begin
				cmd.op = OP_EXP;
				if (cnt_q == LAST_STEP) begin
					state_n = S_FAC;
				end else begin
					cnt_n = cnt_q + 1'b1;
				end
			end
			S_FAC: begin
				cmd.op  = OP_FAC;
				state_n = S_MUL1;
			end
			S_MUL1: begin
				cmd.op  = OP_MUL1;
				state_n = S_MUL2;
			end
			S_MUL2: begin
				cmd.op  = OP_MUL2;
				state_n = sts.last ? S_OUT1 : S_IDLE;
			end
			S_OUT1: begin
				cmd.op  = OP_OUT1;
				state_n = S_OUT2;
			end
			S_OUT2: begin
				if (sts.out_free) begin
					cmd.op  = OP_OUT2;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
		end
	end

	`GPKPE_ASSERT_NXT(a_accept_prep, clk, arst_n, item_valid && (state_q == S_IDLE), state_q == S_PREP)
	`GPKPE_ASSERT_IMP(a_step_range, clk, arst_n, (state_q == S_DIV) || (state_q == S_EXP), cnt_q <= LAST_STEP)
	`GPKPE_ASSERT_NXT(a_no_mid_result, clk, arst_n, (state_q == S_MUL2) && !sts.last, state_q == S_IDLE)

endmodule

[src/gpkpe_datapath.sv]
// Arithmetic, configuration registers and result register of the evaluator
module gpkpe_datapath
	import gpkpe_pkg::*;
#(
	parameter int PRODUCT_FRAC_BITS = PRODUCT_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  item_t       item_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result_data
);

	localparam int P    = PRODUCT_FRAC_BITS;
	localparam int PW   = P + 1;
	localparam int H    = PW / 2;
	localparam int CW   = COORD_WIDTH;
	localparam int NUMW = 32 + CW;
	localparam int SH   = P - 8;
	localparam int DN   = 40 - P;
	localparam int WQW  = CW + 40;
	localparam int MSW  = 2 * PW + 1;
	localparam int OSW  = 24 + PW + 1;
	localparam logic [PW-1:0] ONE_P  = {1'b1, {P{1'b0}}};
	localparam logic [41:0]   F_RND  = (42'd1 << DN) >> 1;
	localparam logic [21:0]   ARG_MAX = 22'h200000;

	function automatic logic [21:0] clamp_arg(input logic [63:0] v);
		return (v > 64'h200000) ? ARG_MAX : v[21:0];
	endfunction

	// configuration
	logic        ktype_q;
	logic [23:0] scale_q;
	logic [31:0] nugget_q;

	// item fields
	logic [CW-1:0] d_q, w_q;
	logic          matern_q, latent_q, diag_q, last_q;

	// working registers
	logic [NUMW-1:0] num_q;
	logic [55:0]     sq_q;
	logic [38:0]     q_q;
	logic [CW-1:0]   rem_q;
	logic [21:0]     dq_q;
	logic [21:0]     arg_q;
	logic [CW+31:0]  pl_q;
	logic [CW+6:0]   ph_q;
	logic [42:0]     bb_q;
	logic [26:0]     p_q;
	logic [32:0]     r_q;
	logic [PW-1:0]   fr_q;
	logic [PW-1:0]   rp_q;
	logic [2*PW-H-1:0] pph_q;
	logic [PW+H-1:0]   ppl_q;
	logic [24+PW-H-1:0] oh_q;
	logic [24+H-1:0]    ol_q;
	logic              out_valid_q;
	result_t           out_q;

	// combinational terms
	logic signed [CW:0] diff;
	logic [CW:0]        neg;
	logic [CW-1:0]      d_abs;
	logic [32:0]        d33;
	logic [27:0]        dc;
	logic [CW-1:0]      wd;
	logic [NUMW:0]      nsum, lsum;
	logic [CW-4:0]      nhi;
	logic               div_skip;
	logic [56:0]        qsum;
	logic [CW:0]        trial;
	logic               ge;
	logic [CW:0]        rem_sub;
	logic [21:0]        dq_n;
	logic [WQW-1:0]     wq, wqr;
	logic [58:0]        recip;
	logic [32:0]        base;
	logic [64:0]        em;
	logic [59:0]        fm_s;
	logic [43:0]        fm;
	logic [32:0]        f33;
	logic [41:0]        fsh;
	logic [MSW-1:0]     msum;
	logic [P+2:0]       rp_n;
	logic [OSW-1:0]     osum;
	logic [33:0]        v;
	logic [34:0]        vt;

	always_comb begin
		diff  = $signed({item_data.first_value[CW-1], item_data.first_value})
			- $signed({item_data.second_value[CW-1], item_data.second_value});
		neg   = -diff;
		d_abs = diff[CW] ? neg[CW-1:0] : diff[CW-1:0];

		d33 = 33'(d_q);
		dc  = (d33 > 33'h8000000) ? 28'h8000000 : d33[27:0];

		wd       = (w_q == '0) ? CW'(1) : w_q;
		nsum     = {1'b0, num_q} + ((NUMW+1)'(wd) << 13);
		nhi      = nsum[NUMW:36];
		div_skip = ({3'b000, nhi} >= wd);
		lsum     = {1'b0, num_q} + (NUMW+1)'(32'h20000000);

		qsum = {1'b0, sq_q} + 57'd32768;

		trial   = {rem_q, dq_q[21]};
		ge      = (trial >= {1'b0, wd});
		rem_sub = ge ? (trial - {1'b0, wd}) : trial;
		dq_n    = {dq_q[20:0], ge};

		wq  = {1'b0, ph_q, 32'b0} + WQW'(pl_q);
		wqr = wq + WQW'(32768);

		recip = {32'b0, bb_q[42:16]} * 59'(32'hAAAAAAAB);

		base = (cmd.step == '0) ? 33'h100000000 : r_q;
		em   = 65'(base) * 65'(exp_bit(cmd.step)) + 65'h80000000;

		fm_s = 60'(r_q) * 60'(p_q) + 60'd32768;
		fm   = fm_s[59:16];
		if (matern_q) begin
			f33 = (fm > 44'h100000000) ? 33'h100000000 : fm[32:0];
		end else begin
			f33 = r_q;
		end
		fsh = (({1'b0, f33, 8'b0}) + F_RND) >> DN;

		msum = {1'b0, pph_q, {H{1'b0}}} + MSW'(ppl_q) + (MSW'(1) << (P - 1));
		rp_n = msum[MSW-1:P];

		osum = {1'b0, oh_q, {H{1'b0}}} + OSW'(ol_q) + (OSW'(1) << (SH - 1));
		v    = osum[OSW-1:SH];
		vt   = {1'b0, v} + (diag_q ? 35'(nugget_q) : 35'd0);
	end

	assign sts.matern   = matern_q;
	assign sts.latent   = latent_q;
	assign sts.last     = last_q;
	assign sts.div_skip = div_skip;
	assign sts.out_free = !out_valid_q || result_ready;

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ktype_q     <= 1'b0;
			scale_q     <= 24'd65536;
			nugget_q    <= '0;
			rp_q        <= ONE_P;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KERNEL_TYPE:  ktype_q  <= cfg_data[0];
					CFG_OUTPUT_SCALE: scale_q  <= cfg_data[23:0];
					CFG_NUGGET:       nugget_q <= cfg_data;
					default:          ;
				endcase
			end
			if (cmd.op == OP_MUL2) begin
				rp_q <= (rp_n > (P+3)'(ONE_P)) ? ONE_P : rp_n[PW-1:0];
			end else if (cmd.op == OP_OUT2) begin
				rp_q <= ONE_P;
			end
			if (cmd.op == OP_OUT2) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				d_q      <= d_abs;
				w_q      <= item_data.dim_weight;
				latent_q <= item_data.latent_dim;
				diag_q   <= item_data.on_diagonal;
				last_q   <= item_data.last_dim;
				matern_q <= (ktype_q == KT_MATERN);
			end
			OP_PREP: begin
				num_q <= NUMW'(SQRT5_Q30) * NUMW'(d_q);
				sq_q  <= 56'(dc) * 56'(dc);
			end
			OP_ARG: begin
				q_q <= qsum[54:16];
				if (latent_q) begin
					arg_q <= clamp_arg(64'(lsum[NUMW:30]));
				end else if (div_skip) begin
					arg_q <= ARG_MAX;
				end else begin
					rem_q <= {3'b000, nhi};
					dq_q  <= nsum[35:14];
				end
			end
			OP_DIV: begin
				rem_q <= rem_sub[CW-1:0];
				dq_q  <= dq_n;
				if (cmd.step == LAST_STEP) begin
					arg_q <= clamp_arg(64'(dq_n));
				end
			end
			OP_GW1: begin
				arg_q <= clamp_arg(64'(q_q));
				pl_q  <= (CW+32)'(w_q) * (CW+32)'(q_q[31:0]);
				ph_q  <= (CW+7)'(w_q) * (CW+7)'(q_q[38:32]);
			end
			OP_GW2: begin
				arg_q <= (wq > (WQW'(1) << 37)) ? ARG_MAX : clamp_arg(64'(wqr[WQW-1:16]));
			end
			OP_POLY1: begin
				bb_q <= 43'(arg_q) * 43'(arg_q) + 43'd98304;
			end
			OP_POLY2: begin
				p_q <= 27'd65536 + 27'(arg_q) + 27'(recip[58:33]);
			end
			OP_EXP: begin
				r_q <= arg_q[cmd.step] ? em[64:32] : base;
			end
			OP_FAC: begin
				fr_q <= (fsh > 42'(ONE_P)) ? ONE_P : fsh[PW-1:0];
			end
			OP_MUL1: begin
				ppl_q <= (PW+H)'(rp_q) * (PW+H)'(fr_q[H-1:0]);
				pph_q <= (2*PW-H)'(rp_q) * (2*PW-H)'(fr_q[PW-1:H]);
			end
			OP_OUT1: begin
				ol_q <= (24+H)'(scale_q) * (24+H)'(rp_q[H-1:0]);
				oh_q <= (24+PW-H)'(scale_q) * (24+PW-H)'(rp_q[PW-1:H]);
			end
			OP_OUT2: begin
				out_q.saturated    <= (vt > 35'hFFFFFFFF);
				out_q.kernel_value <= (vt > 35'hFFFFFFFF) ? 32'hFFFFFFFF : vt[31:0];
			end
			default: ;
		endcase
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

endmodule

[src/gp_kernel_pair_evaluator_unit.sv]
// Top level: Matern 5/2 / Gaussian correlation entry evaluator
// Per transaction: a weighted Matern item runs two 22-step loops (restoring divider, exp bits);
//   a latent Matern item or an out-of-range argument skips the divider; a Gaussian item runs only
//   the exp loop; a last dimension adds the output steps, and its result is valid once idle again.
// Throughput: one item at a time, set by the serial divider and the shared exp multiplier.
// The result register frees the input side: the next transaction is taken while one waits.
// Reset (arst_n low): sequencer idle, product 1.0, registers kernel 0, scale 1.0, nugget 0.
module gp_kernel_pair_evaluator_unit
	import gpkpe_pkg::*;
#(
	parameter int PRODUCT_FRAC_BITS = PRODUCT_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item_data,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	gpkpe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// the datapath latches the transaction on the load command
	gpkpe_datapath #(
		.PRODUCT_FRAC_BITS (PRODUCT_FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item_data    (item_data),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

endmodule
